// ===== sv/dre_pkg.sv =====
// Package for the DAG reachability engine: opcodes, sequencer states,
// beat payload types and sizing constants. No dependencies.
`default_nettype none
package dre_pkg;

  localparam int unsigned NUM_VERT = 64;
  localparam int unsigned VW       = $clog2(NUM_VERT);
  localparam int unsigned CW       = 7;
  localparam int unsigned DW       = 7;

  typedef enum logic [2:0] {
    OP_CLEAR     = 3'd0,
    OP_INSERT    = 3'd1,
    OP_TEST_EDGE = 3'd2,
    OP_TEST_VERT = 3'd3,
    OP_CYCLE     = 3'd4,
    OP_LIST      = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_FIN,
    ST_SCAN,
    ST_POP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]    opcode;
    logic [VW-1:0] from_vertex;
    logic [VW-1:0] to_vertex;
  } in_t;

  typedef struct packed {
    logic          answer_flag;
    logic [VW-1:0] listed_vertex;
    logic          vertex_present;
    logic          last_item;
  } out_t;

endpackage
`default_nettype wire

// ===== sv/dre_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data held between reads. No dependencies.
`default_nettype none
module dre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== sv/dre_prio_enc.sv =====
// Lowest-index priority encoder shared by every search step.
// Depends on dre_pkg.
`default_nettype none
module dre_prio_enc
  import dre_pkg::*;
(
  input  wire logic [NUM_VERT-1:0] req_i,
  output logic                     any_o,
  output logic [VW-1:0]            idx_o
);

  always_comb begin
    idx_o = '0;
    for (int i = NUM_VERT - 1; i >= 0; i--) begin
      if (req_i[i]) begin
        idx_o = VW'(i);
      end
    end
  end

  assign any_o = |req_i;

endmodule
`default_nettype wire

// ===== sv/dag_reachability_engine.sv =====
// Top level of the DAG reachability engine: sequencer, adjacency stores,
// search stack. Depends on dre_pkg, dre_ram and dre_prio_enc.
//
// One input beat is taken at a time; in_stall_o stays high until its last
// result beat is loaded into the output register. Clear, test vertex and
// unused opcodes go from idle straight to the finish state; insert and test
// edge pass through a read state first. In a search (cycle check, ancestor
// list) each step reads one adjacency row from RAM and picks the lowest
// unvisited neighbor below active_count with one priority encoder; a
// backtrack reads the stack RAM. An output stall can hold a search. The
// matrix is held twice (rows and columns) so that successor and
// predecessor scans each read one row; per-row valid bits make a clear
// take effect at once.
`default_nettype none
module dag_reachability_engine
  import dre_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire in_t           in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output out_t               out_data_o,
  input  wire logic          cfg_we_i,
  input  wire logic [CW-1:0] cfg_wdata_i
);

  state_e state_q, state_d;
  logic [CW-1:0]       active_q;
  logic [2:0]          op_q, op_d;
  logic [VW-1:0]       from_q, from_d, to_q, to_d;
  logic [VW-1:0]       top_q, top_d, pend_q, pend_d;
  logic                pend_v_q, pend_v_d, list_q, list_d, flag_q, flag_d;
  logic [DW-1:0]       depth_q, depth_d, depth_m1, depth_m2;
  logic [NUM_VERT-1:0] visited_q, visited_d;
  logic [NUM_VERT-1:0] fwd_vld_q, fwd_vld_d, tr_vld_q, tr_vld_d;
  out_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                fwd_we, tr_we, adj_re, stk_we, stk_re;
  logic [VW-1:0]       fwd_waddr, tr_waddr, fwd_raddr, tr_raddr, stk_waddr, stk_raddr;
  logic [NUM_VERT-1:0] fwd_wdata, tr_wdata, fwd_rdata, tr_rdata;
  logic [VW-1:0]       stk_rdata;

  logic [NUM_VERT-1:0] lim_mask, row, cand, fwd_row_rd, tr_row_rd;
  logic                found, out_free, accept, push_ok;
  logic [VW-1:0]       nxt;

  dre_ram #(.WIDTH(NUM_VERT), .DEPTH(NUM_VERT)) u_fwd_ram (
    .clk_i, .we_i(fwd_we), .waddr_i(fwd_waddr), .wdata_i(fwd_wdata),
    .re_i(adj_re), .raddr_i(fwd_raddr), .rdata_o(fwd_rdata)
  );

  dre_ram #(.WIDTH(NUM_VERT), .DEPTH(NUM_VERT)) u_tr_ram (
    .clk_i, .we_i(tr_we), .waddr_i(tr_waddr), .wdata_i(tr_wdata),
    .re_i(adj_re), .raddr_i(tr_raddr), .rdata_o(tr_rdata)
  );

  dre_ram #(.WIDTH(VW), .DEPTH(NUM_VERT)) u_stack_ram (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(top_q),
    .re_i(stk_re), .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  dre_prio_enc u_prio_enc (.req_i(cand), .any_o(found), .idx_o(nxt));

  always_comb begin
    for (int j = 0; j < NUM_VERT; j++) begin
      lim_mask[j] = (CW'(j) < active_q);
    end
  end

  assign row        = list_q ? (tr_vld_q[top_q] ? tr_rdata : '0)
                             : (fwd_vld_q[top_q] ? fwd_rdata : '0);
  assign cand       = row & ~visited_q & lim_mask;
  assign fwd_row_rd = fwd_vld_q[from_q] ? fwd_rdata : '0;
  assign tr_row_rd  = tr_vld_q[to_q] ? tr_rdata : '0;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign push_ok    = found && (!list_q || !pend_v_q || out_free);
  assign depth_m1   = depth_q - DW'(1);
  assign depth_m2   = depth_q - DW'(2);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.opcode) inside
            OP_INSERT, OP_TEST_EDGE: state_d = ST_RD;
            OP_CYCLE: state_d = (in_data_i.from_vertex == in_data_i.to_vertex)
                                ? ST_FIN : ST_SCAN;
            OP_LIST:  state_d = ST_SCAN;
            default:  state_d = ST_FIN;
          endcase
        end
      end
      ST_RD:   state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      ST_SCAN: begin
        if (!found) begin
          state_d = (depth_q == DW'(1)) ? ST_DONE : ST_POP;
        end
      end
      ST_POP:  state_d = ST_SCAN;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d      = op_q;
    from_d    = from_q;
    to_d      = to_q;
    top_d     = top_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    list_d    = list_q;
    flag_d    = flag_q;
    depth_d   = depth_q;
    visited_d = visited_q;
    fwd_vld_d = fwd_vld_q;
    tr_vld_d  = tr_vld_q;
    out_d     = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    fwd_we    = 1'b0;
    tr_we     = 1'b0;
    fwd_waddr = from_q;
    tr_waddr  = to_q;
    fwd_wdata = fwd_row_rd | (NUM_VERT'(1) << to_q);
    tr_wdata  = tr_row_rd | (NUM_VERT'(1) << from_q);
    adj_re    = 1'b0;
    fwd_raddr = top_q;
    tr_raddr  = top_q;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_waddr = depth_m1[VW-1:0];
    stk_raddr = depth_m2[VW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d   = in_data_i.opcode;
          from_d = in_data_i.from_vertex;
          to_d   = in_data_i.to_vertex;
          list_d = (in_data_i.opcode == OP_LIST);
          flag_d = 1'b0;
          case (in_data_i.opcode) inside
            OP_CLEAR: begin
              fwd_vld_d = '0;
              tr_vld_d  = '0;
            end
            OP_INSERT, OP_TEST_EDGE: begin
              adj_re    = 1'b1;
              fwd_raddr = in_data_i.from_vertex;
              tr_raddr  = in_data_i.to_vertex;
            end
            OP_TEST_VERT: flag_d = ({1'b0, in_data_i.to_vertex} < active_q);
            OP_CYCLE, OP_LIST: begin
              if (in_data_i.opcode == OP_CYCLE &&
                  in_data_i.from_vertex == in_data_i.to_vertex) begin
                flag_d = 1'b1;
              end else begin
                visited_d = NUM_VERT'(1) << in_data_i.to_vertex;
                top_d     = in_data_i.to_vertex;
                depth_d   = DW'(1);
                pend_v_d  = 1'b0;
                adj_re    = 1'b1;
                fwd_raddr = in_data_i.to_vertex;
                tr_raddr  = in_data_i.to_vertex;
              end
            end
            default: flag_d = 1'b0;
          endcase
        end
      end
      ST_RD: begin
        if (op_q == OP_INSERT) begin
          fwd_we           = 1'b1;
          tr_we            = 1'b1;
          fwd_vld_d[from_q] = 1'b1;
          tr_vld_d[to_q]    = 1'b1;
          flag_d           = 1'b0;
        end else begin
          flag_d = fwd_row_rd[to_q];
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_d       = '{answer_flag: flag_q, listed_vertex: '0,
                          vertex_present: 1'b0, last_item: 1'b1};
          out_valid_d = 1'b1;
        end
      end
      ST_SCAN: begin
        if (found) begin
          if (push_ok) begin
            visited_d[nxt] = 1'b1;
            if (list_q) begin
              if (pend_v_q) begin
                out_d       = '{answer_flag: 1'b0, listed_vertex: pend_q,
                                vertex_present: 1'b1, last_item: 1'b0};
                out_valid_d = 1'b1;
              end
              pend_d   = nxt;
              pend_v_d = 1'b1;
            end
            stk_we    = 1'b1;
            top_d     = nxt;
            depth_d   = depth_q + DW'(1);
            adj_re    = 1'b1;
            fwd_raddr = nxt;
            tr_raddr  = nxt;
          end
        end else if (depth_q != DW'(1)) begin
          stk_re  = 1'b1;
          depth_d = depth_m1;
        end
      end
      ST_POP: begin
        top_d     = stk_rdata;
        adj_re    = 1'b1;
        fwd_raddr = stk_rdata;
        tr_raddr  = stk_rdata;
      end
      ST_DONE: begin
        if (out_free) begin
          if (list_q) begin
            out_d = '{answer_flag: 1'b0, listed_vertex: pend_v_q ? pend_q : '0,
                      vertex_present: pend_v_q, last_item: 1'b1};
          end else begin
            out_d = '{answer_flag: visited_q[from_q], listed_vertex: '0,
                      vertex_present: 1'b0, last_item: 1'b1};
          end
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      depth_q     <= '0;
      pend_v_q    <= 1'b0;
      fwd_vld_q   <= '0;
      tr_vld_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      pend_v_q    <= pend_v_d;
      fwd_vld_q   <= fwd_vld_d;
      tr_vld_q    <= tr_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    from_q    <= from_d;
    to_q      <= to_d;
    top_q     <= top_d;
    pend_q    <= pend_d;
    list_q    <= list_d;
    flag_q    <= flag_d;
    visited_q <= visited_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== sv/dre_checker.sv =====
// Port-level checker for the DAG reachability engine, bound to the top.
// Depends on dre_pkg.
`default_nettype none
module dre_assert_checker
  import dre_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_data_o
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // an accepted beat blocks the next one
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous beat in work");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.vertex_present |-> out_data_o.listed_vertex == '0)
    else $error("listed vertex set without a vertex");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.vertex_present |-> out_data_o.last_item)
    else $error("result without vertex is not last");

endmodule

bind dag_reachability_engine dre_assert_checker u_dre_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .out_data_o
);
`default_nettype wire
